### rtl/pctm_pkg.sv
package pctm_pkg;

    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned NUM_W   = 16;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned INDEX_W = 2;

    localparam logic [MODE_W-1:0] MODE_RESCALE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESCALE_MASK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BIN_INSIDE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BIN_OUTSIDE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SATURATE      = 3'd4;

    localparam logic [INDEX_W-1:0] REG_THRESHOLD_FIRST  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_THRESHOLD_SECOND = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MODE             = 2'd2;

    localparam logic [PIXEL_W-1:0] PIXEL_MIN = 8'd0;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

    typedef struct packed {
        logic [NUM_W-1:0]   rem;
        logic [PIXEL_W-1:0] den;
        logic [PIXEL_W-1:0] quo;
        logic               bypass;
        logic [PIXEL_W-1:0] byp_val;
    } div_item_t;

    typedef struct packed {
        logic             qbit;
        logic [NUM_W-1:0] rem;
    } div_step_t;

    // One restoring step: try to take the divisor shifted left by sh from the partial remainder.
    function automatic div_step_t div_step(input logic [NUM_W-1:0]   rem,
                                           input logic [PIXEL_W-1:0] den,
                                           input logic [2:0]         sh);
        logic [NUM_W-1:0] shifted;
        div_step_t        res;
        shifted = {{(NUM_W-PIXEL_W){1'b0}}, den} << sh;
        if (rem >= shifted)
        begin
            res.qbit = 1'b1;
            res.rem  = rem - shifted;
        end
        else
        begin
            res.qbit = 1'b0;
            res.rem  = rem;
        end
        return res;
    endfunction

endpackage

### rtl/pctm_div_pipe.sv
module pctm_div_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pctm_pkg::div_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pctm_pkg::div_item_t  out_data
);

    // Two quotient bits are resolved in each stage, most significant first.
    localparam int unsigned NSTAGE = 4;

    logic                v_reg  [NSTAGE];
    pctm_pkg::div_item_t st_reg [NSTAGE];
    logic                en     [NSTAGE+1];

    assign en[NSTAGE] = out_ready;
    assign in_ready   = en[0];
    assign out_valid  = v_reg[NSTAGE-1];
    assign out_data   = st_reg[NSTAGE-1];

    genvar k;
    generate
        for (k = 0; k < NSTAGE; k++)
        begin : g_stage
            localparam logic [2:0] SH_HI = 3'(7 - 2 * k);
            localparam logic [2:0] SH_LO = 3'(6 - 2 * k);

            logic                prev_valid;
            pctm_pkg::div_item_t prev_data;
            pctm_pkg::div_step_t step_hi;
            pctm_pkg::div_step_t step_lo;
            pctm_pkg::div_item_t st_next;

            if (k == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_data  = in_data;
            end
            else
            begin : g_rest
                assign prev_valid = v_reg[k-1];
                assign prev_data  = st_reg[k-1];
            end

            assign en[k] = !v_reg[k] || en[k+1];

            always_comb
            begin
                step_hi     = pctm_pkg::div_step(prev_data.rem, prev_data.den, SH_HI);
                step_lo     = pctm_pkg::div_step(step_hi.rem, prev_data.den, SH_LO);
                st_next     = prev_data;
                st_next.rem = step_lo.rem;
                st_next.quo = {prev_data.quo[pctm_pkg::PIXEL_W-3:0], step_hi.qbit, step_lo.qbit};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    v_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k] && prev_valid)
                begin
                    st_reg[k] <= st_next;
                end
            end
        end
    endgenerate

    // For a non-bypass item the numerator is below 256 times the divisor, so eight steps leave a proper remainder.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.bypass) |-> (out_data.rem < {8'd0, out_data.den}))
        else $error("divider remainder not below divisor");

    a_in_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!v_reg[0] && !v_reg[1] && !v_reg[2] && !v_reg[3]) |-> in_ready)
        else $error("empty divider refused an item");

    a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data.quo)))
        else $error("stalled quotient changed");

endmodule

### rtl/pixel_contrast_threshold_map.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] pixel_in
// m_axis    out        tdata[7:0] pixel_out
// cfg       in         cfg_index 0 first threshold, 1 second threshold, 2 mode
//
// One pixel is taken in every clock while the output is not stalled; a taken pixel passes in order
// through a preparation stage, four stages of a radix-4 restoring divider and the output register.
// Reset clears all valid bits and sets the thresholds to 0 and 255 and the mode to rescale.
// An output stall holds each full stage whose later stages are all full; items still move into empty stages.
module pixel_contrast_threshold_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pctm_pkg::PIXEL_W-1:0]    s_axis_tdata,   // [7:0] pixel_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pctm_pkg::PIXEL_W-1:0]    m_axis_tdata,   // [7:0] pixel_out
    input  logic                            cfg_wen,
    input  logic [pctm_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [pctm_pkg::PIXEL_W-1:0]    cfg_wdata
);

    logic [pctm_pkg::PIXEL_W-1:0] thr_first_reg;
    logic [pctm_pkg::PIXEL_W-1:0] thr_second_reg;
    logic [pctm_pkg::MODE_W-1:0]  mode_reg;

    logic                s1_valid_reg;
    pctm_pkg::div_item_t s1_data_reg;
    pctm_pkg::div_item_t s1_data_next;
    logic                s1_en;

    logic                div_in_ready;
    logic                div_out_valid;
    logic                div_out_ready;
    pctm_pkg::div_item_t div_out_data;

    logic                         out_valid_reg;
    logic [pctm_pkg::PIXEL_W-1:0] out_data_reg;
    logic [pctm_pkg::PIXEL_W-1:0] out_data_next;

    logic [pctm_pkg::PIXEL_W-1:0] pix;
    logic [pctm_pkg::PIXEL_W-1:0] lo;
    logic [pctm_pkg::PIXEL_W-1:0] hi;
    logic [pctm_pkg::PIXEL_W-1:0] pix_eff;
    logic [pctm_pkg::PIXEL_W-1:0] offset;
    logic [pctm_pkg::PIXEL_W-1:0] span;
    logic                         rising;
    logic                         below;
    logic                         above;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_first_reg  <= pctm_pkg::PIXEL_MIN;
            thr_second_reg <= pctm_pkg::PIXEL_MAX;
            mode_reg       <= pctm_pkg::MODE_RESCALE;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                pctm_pkg::REG_THRESHOLD_FIRST:  thr_first_reg  <= cfg_wdata;
                pctm_pkg::REG_THRESHOLD_SECOND: thr_second_reg <= cfg_wdata;
                pctm_pkg::REG_MODE:             mode_reg       <= cfg_wdata[pctm_pkg::MODE_W-1:0];
                default:                        ;
            endcase
        end
    end

    // Preparation: clamp the pixel to the window (mask mode: above goes to lo); rescale is 255*offset/span.
    always_comb
    begin
        pix    = s_axis_tdata;
        rising = thr_first_reg < thr_second_reg;
        lo     = rising ? thr_first_reg : thr_second_reg;
        hi     = rising ? thr_second_reg : thr_first_reg;
        below  = pix < lo;
        above  = pix > hi;

        if (below)
        begin
            pix_eff = lo;
        end
        else if (above)
        begin
            pix_eff = (mode_reg == pctm_pkg::MODE_RESCALE_MASK) ? lo : hi;
        end
        else
        begin
            pix_eff = pix;
        end

        offset = rising ? (pix_eff - thr_first_reg) : (thr_first_reg - pix_eff);
        span   = hi - lo;

        s1_data_next.rem     = {offset, 8'd0} - {8'd0, offset};
        s1_data_next.den     = span;
        s1_data_next.quo     = '0;
        s1_data_next.bypass  = 1'b1;
        s1_data_next.byp_val = pctm_pkg::PIXEL_MIN;

        case (mode_reg)
            pctm_pkg::MODE_RESCALE, pctm_pkg::MODE_RESCALE_MASK:
            begin
                s1_data_next.bypass = (span == pctm_pkg::PIXEL_MIN);
            end
            pctm_pkg::MODE_BIN_INSIDE:
            begin
                s1_data_next.byp_val = (below || above) ? pctm_pkg::PIXEL_MIN : pctm_pkg::PIXEL_MAX;
            end
            pctm_pkg::MODE_BIN_OUTSIDE:
            begin
                s1_data_next.byp_val = (below || above) ? pctm_pkg::PIXEL_MAX : pctm_pkg::PIXEL_MIN;
            end
            pctm_pkg::MODE_SATURATE:
            begin
                s1_data_next.byp_val = below ? lo : (above ? hi : pix);
            end
            default:
            begin
                s1_data_next.byp_val = pctm_pkg::PIXEL_MIN;
            end
        endcase
    end

    assign s1_en         = !s1_valid_reg || div_in_ready;
    assign s_axis_tready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && s_axis_tvalid)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    pctm_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (div_in_ready),
        .in_data   (s1_data_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_data  (div_out_data)
    );

    assign div_out_ready = !out_valid_reg || m_axis_tready;
    assign out_data_next = div_out_data.bypass ? div_out_data.byp_val : div_out_data.quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> div_out_ready)
        else $error("empty output register refused a transfer");

    a_num_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_data_reg.bypass) |->
        (s1_data_reg.den != 8'd0 && s1_data_reg.rem <= ({8'd0, s1_data_reg.den} << 8)
                                                      - {8'd0, s1_data_reg.den}))
        else $error("rescale numerator outside the window span");

    a_out_from_divider: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(div_out_valid))
        else $error("output became valid without a divider result");

endmodule
